// ----- rtl/ps2mpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared widths, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

  // Width of cursor positions and clamp bounds.
  localparam int unsigned CoordW = 12;
  localparam int unsigned LenW   = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  // Register indexes (byte address is 4 * index).
  localparam logic [2:0] REG_PACKET_LEN = 3'd0;
  localparam logic [2:0] REG_X_LOW      = 3'd1;
  localparam logic [2:0] REG_X_HIGH     = 3'd2;
  localparam logic [2:0] REG_Y_LOW      = 3'd3;
  localparam logic [2:0] REG_Y_HIGH     = 3'd4;

  localparam logic [LenW-1:0]   RST_PACKET_LEN = LenW'(3);
  localparam logic [CoordW-1:0] RST_X_LOW      = CoordW'(14);
  localparam logic [CoordW-1:0] RST_X_HIGH     = CoordW'(629);
  localparam logic [CoordW-1:0] RST_Y_LOW      = CoordW'(14);
  localparam logic [CoordW-1:0] RST_Y_HIGH     = CoordW'(469);
  localparam logic [CoordW-1:0] RST_POS        = CoordW'(50);

  // Byte position within a packet.
  localparam logic [IdxW-1:0] IDX_BUTTONS = 2'd0;
  localparam logic [IdxW-1:0] IDX_DX      = 2'd1;
  localparam logic [IdxW-1:0] IDX_DY      = 2'd2;
  localparam logic [IdxW-1:0] IDX_WHEEL   = 2'd3;

  typedef struct packed {
    logic [LenW-1:0]   packet_len;
    logic [CoordW-1:0] x_low;
    logic [CoordW-1:0] x_high;
    logic [CoordW-1:0] y_low;
    logic [CoordW-1:0] y_high;
  } cfg_t;

endpackage : ps2mpt_pkg
`default_nettype wire

// ----- rtl/ps2mpt_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker configuration registers
// APB-style register file holding the packet length and the clamp bounds.
// ----------------------------------------------------------------------------
module ps2mpt_cfg
  import ps2mpt_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PACKET_LEN: cfg_d.packet_len = pwdata[LenW-1:0];
        REG_X_LOW:      cfg_d.x_low      = pwdata[CoordW-1:0];
        REG_X_HIGH:     cfg_d.x_high     = pwdata[CoordW-1:0];
        REG_Y_LOW:      cfg_d.y_low      = pwdata[CoordW-1:0];
        REG_Y_HIGH:     cfg_d.y_high     = pwdata[CoordW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PACKET_LEN: prdata = DataW'(cfg_q.packet_len);
      REG_X_LOW:      prdata = DataW'(cfg_q.x_low);
      REG_X_HIGH:     prdata = DataW'(cfg_q.x_high);
      REG_Y_LOW:      prdata = DataW'(cfg_q.y_low);
      REG_Y_HIGH:     prdata = DataW'(cfg_q.y_high);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.packet_len <= RST_PACKET_LEN;
      cfg_q.x_low      <= RST_X_LOW;
      cfg_q.x_high     <= RST_X_HIGH;
      cfg_q.y_low      <= RST_Y_LOW;
      cfg_q.y_high     <= RST_Y_HIGH;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule : ps2mpt_cfg
`default_nettype wire

// ----- rtl/ps2mpt_clamp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker axis update
// Applies a signed byte movement to one coordinate and clamps it to bounds.
// ----------------------------------------------------------------------------
module ps2mpt_clamp
  import ps2mpt_pkg::*;
(
  input  wire logic [CoordW-1:0] pos_i,
  input  wire logic [7:0]        delta_i,
  input  wire logic              sub_i,
  input  wire logic [CoordW-1:0] low_i,
  input  wire logic [CoordW-1:0] high_i,
  output logic      [CoordW-1:0] pos_o
);

  localparam int unsigned SumW = CoordW + 2;

  logic signed [SumW-1:0] delta_ext;
  logic signed [SumW-1:0] sum;
  logic signed [SumW-1:0] low_ext;
  logic signed [SumW-1:0] high_ext;
  logic signed [SumW-1:0] lifted;
  logic signed [SumW-1:0] clamped;

  assign delta_ext = SumW'(signed'(delta_i));
  assign low_ext   = signed'({2'b00, low_i});
  assign high_ext  = signed'({2'b00, high_i});
  assign sum       = sub_i ? (signed'({2'b00, pos_i}) - delta_ext)
                           : (signed'({2'b00, pos_i}) + delta_ext);

  // The upper bound is applied last, so it wins when the bounds cross.
  assign lifted  = (sum < low_ext) ? low_ext : sum;
  assign clamped = (lifted > high_ext) ? high_ext : lifted;
  assign pos_o   = clamped[CoordW-1:0];

endmodule : ps2mpt_clamp
`default_nettype wire

// ----- rtl/ps2_mouse_packet_tracker_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Groups raw mouse bytes into 3- or 4-byte packets and tracks a clamped
// cursor position, giving one beat of buttons and position per packet.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Beat contents
//   rx        in         in_valid_i / in_ready_o   rx_byte_i
//   cursor    out        out_valid_o / out_ready_i buttons, cursor_x/y
//   config    in         APB psel/penable/pready   five registers
//
// A byte is taken into an input register and then folded into the packet
// state; a completing byte loads the result register, so a result reaches the
// output through the input register and then the result register.
// One byte can be accepted in every cycle. The only stall is a completing
// byte facing a full result register that is not being drained; in_ready_o
// then drops until out_ready_i frees it.
// Reset clears the byte index and both handshakes, loads the register
// defaults and puts the cursor at (50, 50). Packet bytes have no reset.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit
  import ps2mpt_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Raw byte channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [7:0]        rx_byte_i,
  // Packet result channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   left_button_o,
  output logic                   right_button_o,
  output logic      [CoordW-1:0] cursor_x_o,
  output logic      [CoordW-1:0] cursor_y_o,
  // Configuration port.
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic      [DataW-1:0]  prdata,
  output logic                   pready
);

  cfg_t cfg;

  ps2mpt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Input register.
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q;
  logic       in_fire;

  // Packet state.
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [7:0]        bytes_q [3];
  logic [CoordW-1:0] pos_x_q, pos_y_q;

  // Result register.
  logic              out_valid_q, out_valid_d;
  logic              left_q, right_q;
  logic [CoordW-1:0] cur_x_q, cur_y_q;

  logic              len4;
  logic              s1_done;
  logic              s1_adv;
  logic [7:0]        eff_b0, eff_b1, eff_b2;
  logic [CoordW-1:0] new_x, new_y;

  // Lengths of four and above act as four, everything else as three.
  assign len4 = (cfg.packet_len >= LenW'(4));

  // A byte at or past the last index of the current length closes the packet,
  // which also covers the length being lowered in the middle of a packet.
  assign s1_done = len4 ? (idx_q == IDX_WHEEL) : (idx_q >= IDX_DY);

  // The byte being processed overrides its slot when it lands in one.
  assign eff_b0 = (idx_q == IDX_BUTTONS) ? s1_byte_q : bytes_q[0];
  assign eff_b1 = (idx_q == IDX_DX)      ? s1_byte_q : bytes_q[1];
  assign eff_b2 = (idx_q == IDX_DY)      ? s1_byte_q : bytes_q[2];

  ps2mpt_clamp u_clamp_x (
    .pos_i   (pos_x_q),
    .delta_i (eff_b1),
    .sub_i   (1'b0),
    .low_i   (cfg.x_low),
    .high_i  (cfg.x_high),
    .pos_o   (new_x)
  );

  // Y grows downward on screen, so mouse Y motion is subtracted.
  ps2mpt_clamp u_clamp_y (
    .pos_i   (pos_y_q),
    .delta_i (eff_b2),
    .sub_i   (1'b1),
    .low_i   (cfg.y_low),
    .high_i  (cfg.y_high),
    .pos_o   (new_y)
  );

  // The held byte moves on unless it would produce a result into a full,
  // stalled result register.
  assign s1_adv     = s1_valid_q && (!s1_done || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (s1_adv) begin
      idx_d = s1_done ? IDX_BUTTONS : idx_q + IdxW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_done) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= IDX_BUTTONS;
      pos_x_q     <= RST_POS;
      pos_y_q     <= RST_POS;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
      if (s1_adv && s1_done) begin
        pos_x_q <= new_x;
        pos_y_q <= new_y;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_byte_q <= rx_byte_i;
    end
    for (int k = 0; k < 3; k++) begin
      if (s1_adv && (idx_q == IdxW'(k))) begin
        bytes_q[k] <= s1_byte_q;
      end
    end
    if (s1_adv && s1_done) begin
      left_q  <= eff_b0[0];
      right_q <= eff_b0[1];
      cur_x_q <= new_x;
      cur_y_q <= new_y;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_button_o  = left_q;
  assign right_button_o = right_q;
  assign cursor_x_o     = cur_x_q;
  assign cursor_y_o     = cur_y_q;

endmodule : ps2_mouse_packet_tracker_unit
`default_nettype wire
